/* sv/c36_pkg.sv */
package c36_pkg;

    localparam int INPUT_BITS_DEF = 10;
    localparam int DIGIT_W        = 6;
    localparam int CHAR_W         = 7;
    localparam int RADIX          = 36;

    localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0]  ASCII_A    = CHAR_W'(8'h41);
    localparam logic [CHAR_W-1:0]  ASCII_NINE = CHAR_W'(8'h39);
    localparam logic [CHAR_W-1:0]  ASCII_Z    = CHAR_W'(8'h5A);

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQR,
        OP_CUBE,
        OP_MULR,
        OP_CORR,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT
    } wait_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_Q_NZ,
        COND_MORE
    } cond_t;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_LOAD = 3'd0;
    localparam step_t ST_SQR  = 3'd1;
    localparam step_t ST_CUBE = 3'd2;
    localparam step_t ST_MULR = 3'd3;
    localparam step_t ST_CORR = 3'd4;
    localparam step_t ST_EMIT = 3'd5;

    typedef struct packed {
        wait_t waitc;
        op_t   op;
        cond_t cond;
        step_t tgt_t;
        step_t tgt_f;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic go;
        logic in_ready;
    } ctl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic q_nz;
        logic more;
    } stat_t;

    // Microcode store. A step waits on its wait condition, then runs its
    // datapath operation and branches on its condition.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        begin
            case (s)
                ST_LOAD: w = '{WAIT_IN,   OP_LOAD, COND_ALWAYS, ST_SQR,  ST_SQR};
                ST_SQR:  w = '{WAIT_NONE, OP_SQR,  COND_ALWAYS, ST_CUBE, ST_CUBE};
                ST_CUBE: w = '{WAIT_NONE, OP_CUBE, COND_ALWAYS, ST_MULR, ST_MULR};
                ST_MULR: w = '{WAIT_NONE, OP_MULR, COND_ALWAYS, ST_CORR, ST_CORR};
                ST_CORR: w = '{WAIT_NONE, OP_CORR, COND_Q_NZ,   ST_MULR, ST_EMIT};
                ST_EMIT: w = '{WAIT_OUT,  OP_EMIT, COND_MORE,   ST_EMIT, ST_LOAD};
                default: w = '{WAIT_NONE, OP_NOP,  COND_ALWAYS, ST_LOAD, ST_LOAD};
            endcase
            return w;
        end
    endfunction

    // Number of base-36 digits needed for the largest cube of a given input width.
    function automatic int max_digits(input int bits);
        longint m;
        longint p;
        int     d;
        begin
            m = ((longint'(1) << bits) - 1);
            m = m * m * m;
            p = RADIX;
            d = 1;
            while (p <= m) begin
                p = p * RADIX;
                d = d + 1;
            end
            return d;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        begin
            if (d < DEC_DIGITS) begin
                return ASCII_ZERO + CHAR_W'(d);
            end else begin
                return ASCII_A + CHAR_W'(d - DEC_DIGITS);
            end
        end
    endfunction

endpackage

/* sv/cube_to_base36_ascii.sv */
// Cubes n_value and sends the cube as base-36 ASCII characters, most significant first.
// An item with D digits (1 to 6 at ten input bits) passes one accept step, two multiply
// steps, a reciprocal-multiply and a correction step per divide-by-36 step, and an emit
// step for each character into the output register, which waits until that register is free.
// A new input is taken only after the last character is emitted. Reset returns the microcode
// step counter to the load step and clears the output valid; datapath registers are not reset.
module cube_to_base36_ascii #(
    parameter int INPUT_BITS = c36_pkg::INPUT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [INPUT_BITS-1:0]       s_n_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [c36_pkg::CHAR_W-1:0]  m_digit_char,
    output logic                        m_last_digit
);
    import c36_pkg::*;

    localparam int CW    = 3 * INPUT_BITS;
    localparam int SW    = 2 * INPUT_BITS;
    localparam int XW    = CW - 2;
    localparam int RW    = XW + 4;
    localparam int PW    = XW + CW;
    localparam int MAXD  = max_digits(INPUT_BITS);
    localparam int IW    = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int DEPTH = 2 ** IW;
    // floor(2^CW / 9): the quotient estimate is exact or one low.
    localparam logic [CW-1:0] RECIP = CW'((64'd1 << CW) / 64'd9);

    ctl_t  ctl;
    stat_t stat;

    logic [INPUT_BITS-1:0] n_reg,   n_next;
    logic [SW-1:0]         sq_reg,  sq_next;
    logic [CW-1:0]         acc_reg, acc_next;
    logic [XW-1:0]         qe_reg,  qe_next;
    logic [DIGIT_W-1:0]    dig_reg [DEPTH];
    logic [DIGIT_W-1:0]    dig_next [DEPTH];
    logic [IW-1:0]         idx_reg, idx_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]     m_char_reg,  m_char_next;
    logic                  m_last_reg,  m_last_next;

    logic [XW-1:0]      x;
    logic [PW-1:0]      prod;
    logic [RW-1:0]      r9;
    logic [RW-1:0]      rem;
    logic               fix;
    logic [XW-1:0]      q_fix;
    logic [DIGIT_W-1:0] digit;

    c36_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    // Divide by 36 as a shift by two and a reciprocal divide by nine.
    always_comb begin
        x     = acc_reg[CW-1:2];
        prod  = PW'(x) * PW'(RECIP);
        r9    = RW'(x) - RW'(qe_reg) * RW'(9);
        fix   = (r9 >= RW'(9));
        q_fix = qe_reg + XW'(fix);
        rem   = fix ? (r9 - RW'(9)) : r9;
        digit = {rem[3:0], acc_reg[1:0]};
    end

    always_comb begin
        stat.in_valid = s_valid;
        stat.out_free = !m_valid_reg || m_ready;
        stat.q_nz     = (q_fix != '0);
        stat.more     = (idx_reg != '0);
    end

    always_comb begin
        n_next       = n_reg;
        sq_next      = sq_reg;
        acc_next     = acc_reg;
        qe_next      = qe_reg;
        dig_next     = dig_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;

        if (ctl.go) begin
            case (ctl.op)
                OP_LOAD: begin
                    n_next   = s_n_value;
                    idx_next = '0;
                end
                OP_SQR: begin
                    sq_next = SW'(n_reg) * SW'(n_reg);
                end
                OP_CUBE: begin
                    acc_next = CW'(sq_reg) * CW'(n_reg);
                end
                OP_MULR: begin
                    qe_next = XW'(prod >> CW);
                end
                OP_CORR: begin
                    dig_next[idx_reg] = digit;
                    acc_next          = CW'(q_fix);
                    if (q_fix != '0) begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
                OP_EMIT: begin
                    m_valid_next = 1'b1;
                    m_char_next  = digit_to_ascii(dig_reg[idx_reg]);
                    m_last_next  = (idx_reg == '0);
                    idx_next     = idx_reg - IW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        n_reg      <= n_next;
        sq_reg     <= sq_next;
        acc_reg    <= acc_next;
        qe_reg     <= qe_next;
        dig_reg    <= dig_next;
        idx_reg    <= idx_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign s_ready      = ctl.in_ready;
    assign m_valid      = m_valid_reg;
    assign m_digit_char = m_char_reg;
    assign m_last_digit = m_last_reg;

`ifndef SYNTHESIS
    a_accept_leaves_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice without conversion");

    a_char_is_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_digit_char >= ASCII_ZERO) && (m_digit_char <= ASCII_NINE))
                 || ((m_digit_char >= ASCII_A) && (m_digit_char <= ASCII_Z)))
        else $error("output character is not a base-36 digit");

    a_digit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.go && (ctl.op == OP_CORR) |-> (idx_reg <= IW'(MAXD - 1)))
        else $error("digit index beyond maximum digit count");
`endif

endmodule

/* sv/c36_seq.sv */
module c36_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  c36_pkg::stat_t  stat,
    output c36_pkg::ctl_t   ctl
);
    import c36_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    uword_t uw;
    logic   go;
    logic   cond_hit;

    always_comb begin
        uw = ucode(step_reg);

        case (uw.waitc)
            WAIT_IN:  go = stat.in_valid;
            WAIT_OUT: go = stat.out_free;
            default:  go = 1'b1;
        endcase

        case (uw.cond)
            COND_Q_NZ: cond_hit = stat.q_nz;
            COND_MORE: cond_hit = stat.more;
            default:   cond_hit = 1'b1;
        endcase

        if (go) begin
            step_next = cond_hit ? uw.tgt_t : uw.tgt_f;
        end else begin
            step_next = step_reg;
        end

        ctl.op       = uw.op;
        ctl.go       = go;
        ctl.in_ready = (uw.waitc == WAIT_IN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_LOAD;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

/* sim/tb_cube_to_base36_ascii.sv */
`timescale 1ns / 100ps

module tb_cube_to_base36_ascii;

    import c36_pkg::*;

    localparam int NBITS      = INPUT_BITS_DEF;
    localparam int MAX_CHARS  = 6;
    localparam int STALL_MAX  = 2000;
    localparam int TAIL_WAIT  = 40;
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } b36_char_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [NBITS-1:0]  s_n_value;
    logic              m_valid;
    logic              m_ready;
    logic [CHAR_W-1:0] m_digit_char;
    logic              m_last_digit;

    b36_char_t char_q[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        n_sent        = 0;
    int        n_chars       = 0;
    int        mismatch_cnt  = 0;
    int        quiet_cycles  = 0;

    cube_to_base36_ascii #(.INPUT_BITS(NBITS)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_n_value    (s_n_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit)
    );

    always #5 aclk = ~aclk;

    // Work out the characters of n cubed, most significant first, and queue them.
    function automatic void predict_cube_chars(input logic [NBITS-1:0] n);
        logic [31:0]        cube;
        logic [DIGIT_W-1:0] digs[MAX_CHARS];
        int                 cnt;
        b36_char_t          c;
        cube = 32'(n) * 32'(n) * 32'(n);
        cnt  = 0;
        do begin
            digs[cnt] = DIGIT_W'(cube % RADIX);
            cube      = cube / RADIX;
            cnt++;
        end while (cube != 0 && cnt < MAX_CHARS);
        for (int k = cnt - 1; k >= 0; k--) begin
            if (digs[k] < DEC_DIGITS) begin
                c.ch = ASCII_ZERO + CHAR_W'(digs[k]);
            end else begin
                c.ch = ASCII_A + CHAR_W'(digs[k] - DEC_DIGITS);
            end
            c.last = (k == 0);
            char_q.push_back(c);
        end
    endfunction

    // Pick an input whose cube has exactly len base-36 digits.
    function automatic logic [NBITS-1:0] number_with_length(input int len);
        int lo[MAX_CHARS] = '{0, 4, 11, 36, 119, 393};
        int hi[MAX_CHARS] = '{3, 10, 35, 118, 392, 1023};
        return NBITS'($urandom_range(hi[len-1], lo[len-1]));
    endfunction

    task automatic send_number(input logic [NBITS-1:0] n);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_n_value <= n;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_cube_chars(n);
        n_sent++;
    endtask

    task automatic wait_for_drain();
        while (char_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Zero, one, both sides of every digit-count boundary, walking ones and alternating bits.
    task automatic test_digit_boundaries();
        int vals[] = '{0, 1, 2, 3, 4, 10, 11, 35, 36, 118, 119, 391, 392, 393, 1023,
                       512, 256, 128, 64, 32, 16, 8, 6, 341, 682};
        foreach (vals[i]) send_number(NBITS'(vals[i]));
    endtask

    task automatic test_random_numbers(input int count);
        for (int i = 0; i < count; i++) begin
            send_number(number_with_length($urandom_range(MAX_CHARS, 1)));
        end
    endtask

    // The sender holds off until the block has emptied, then resumes.
    task automatic test_drain_pause();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait_for_drain();
        test_random_numbers(4);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        b36_char_t e;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready) begin
            n_chars++;
            if (char_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX) begin
                    $display("unexpected beat: char %h last %b", m_digit_char, m_last_digit);
                end
            end else begin
                e = char_q.pop_front();
                if (m_digit_char !== e.ch || m_last_digit !== e.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX) begin
                        $display("mismatch: expected char %h last %b, got char %h last %b",
                                 e.ch, e.last, m_digit_char, m_last_digit);
                    end
                end
            end
        end
    end

    // A run is stuck once no beat moves on either channel until the quiet counter reaches STALL_MAX.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_MAX) begin
            $display("tb_cube_to_base36_ascii: done, errors");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_n_value = '0;
        m_ready   = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_idling(30, 87);
        test_digit_boundaries();
        test_random_numbers(84);
        test_drain_pause();
        set_idling(87, 30);
        test_random_numbers(84);
        set_idling(0, 0);
        test_random_numbers(84);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_for_drain();
        repeat (TAIL_WAIT) @(posedge aclk);

        $display("covered %0d numbers giving %0d characters, cubes of 1 to 6 digits,", n_sent,
                 n_chars);
        $display("under heavy receiver stalls, heavy sender gaps, a drain pause and full rate");
        if (mismatch_cnt == 0) begin
            $display("tb_cube_to_base36_ascii: done, clean");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("tb_cube_to_base36_ascii: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/c36_pkg.sv
sv/c36_seq.sv
sv/cube_to_base36_ascii.sv
sim/tb_cube_to_base36_ascii.sv
